FILE: design/rau_pkg.sv
`timescale 1ns / 1ps
package rau_pkg;
    localparam int unsigned WORD_BITS_DEF = 32;
    localparam int unsigned IO_BITS = 32;

    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_SUB = 2'd1,
        FUNC_MUL = 2'd2,
        FUNC_DIV = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GCD1,
        ST_DIVFA,
        ST_DIVFB,
        ST_MULTA,
        ST_MULTB,
        ST_MULD,
        ST_SUM,
        ST_MULPN,
        ST_MULPD,
        ST_CHECK,
        ST_GCD2,
        ST_DIVRN,
        ST_DIVRD,
        ST_DONE
    } t_state;
endpackage

FILE: design/rational_arith_unit.sv
`timescale 1ns / 1ps
// A zero denominator in add or subtract goes straight to the done state with the error flag set.
// Add or subtract finds the GCD of the denominator magnitudes by repeated division and scales
// both fractions to a common denominator; multiply or divide forms its products directly. A
// result with no zero part is reduced by a second GCD and two divider passes before the strobe.
// One beat at a time: busy stays high through the strobe; the receiver cannot stall the strobe.
// Reset is synchronous, active low, and returns the sequencer to idle.
module rational_arith_unit #(
    parameter int unsigned WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_func,
    input  logic signed [rau_pkg::IO_BITS-1:0] i_a_num,
    input  logic signed [rau_pkg::IO_BITS-1:0] i_a_den,
    input  logic signed [rau_pkg::IO_BITS-1:0] i_b_num,
    input  logic signed [rau_pkg::IO_BITS-1:0] i_b_den,
    output logic                         o_valid,
    output logic signed [rau_pkg::IO_BITS-1:0] o_res_num,
    output logic signed [rau_pkg::IO_BITS-1:0] o_res_den,
    output logic                         o_err
);
    import rau_pkg::*;

    localparam int unsigned W = WORD_BITS;
    localparam int unsigned CW = $clog2(W + 1);

    t_state r_state, n_state;
    logic [1:0]   r_func;
    logic [W-1:0] r_an, r_ad, r_bn, r_bd;
    logic [W-1:0] r_x, r_y;       // gcd working pair
    logic [W-1:0] r_fa, r_fb, r_ta, r_tb, r_n, r_d, r_g;
    logic         r_err;

    // Shared restoring divider: one quotient bit per cycle.
    logic [W-1:0] r_dv_q, r_dv_r, r_dv_d;
    logic [CW-1:0] r_dv_cnt;
    logic          r_dv_busy, dv_go, dv_done;
    logic [W-1:0]  dv_a, dv_b;
    logic [W:0]    dv_trial;

    function automatic logic [W-1:0] mag(input logic [W-1:0] v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [W-1:0] sx(input logic [W-1:0] v, input logic neg);
        return neg ? (~v + 1'b1) : v;
    endfunction

    assign dv_trial = {r_dv_r, r_dv_q[W-1]} - {1'b0, r_dv_d};
    assign dv_done  = r_dv_busy && (r_dv_cnt == CW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_busy <= 1'b0;
            r_dv_cnt  <= '0;
        end else if (dv_go) begin
            r_dv_busy <= 1'b1;
            r_dv_cnt  <= CW'(W);
            r_dv_q    <= dv_a;
            r_dv_r    <= '0;
            r_dv_d    <= dv_b;
        end else if (r_dv_busy) begin
            if (!dv_trial[W]) r_dv_r <= dv_trial[W-1:0];
            else              r_dv_r <= {r_dv_r[W-2:0], r_dv_q[W-1]};
            r_dv_q   <= {r_dv_q[W-2:0], ~dv_trial[W]};
            r_dv_cnt <= r_dv_cnt - 1'b1;
            if (dv_done) r_dv_busy <= 1'b0;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (start) begin
                if (i_func[1]) n_state = ST_MULPN;
                else if (mag(i_a_den[W-1:0]) == '0 || mag(i_b_den[W-1:0]) == '0)
                    n_state = ST_DONE;
                else n_state = ST_GCD1;
            end
            ST_GCD1:  if (r_y == '0) n_state = ST_DIVFA;
            ST_DIVFA: if (dv_done) n_state = ST_DIVFB;
            ST_DIVFB: if (dv_done) n_state = ST_MULTA;
            ST_MULTA: n_state = ST_MULTB;
            ST_MULTB: n_state = ST_MULD;
            ST_MULD:  n_state = ST_SUM;
            ST_SUM:   n_state = ST_CHECK;
            ST_MULPN: n_state = ST_MULPD;
            ST_MULPD: n_state = ST_CHECK;
            ST_CHECK: n_state = (r_n == '0 || r_d == '0) ? ST_DONE : ST_GCD2;
            ST_GCD2:  if (r_y == '0) n_state = ST_DIVRN;
            ST_DIVRN: if (dv_done) n_state = ST_DIVRD;
            ST_DIVRD: if (dv_done) n_state = ST_DONE;
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Divider launch and operand selection.
    always_comb begin
        dv_go = 1'b0;
        dv_a  = r_x;
        dv_b  = r_y;
        case (r_state)
            ST_GCD1, ST_GCD2: begin
                dv_go = (r_y != '0) && !r_dv_busy;
            end
            ST_DIVFA: begin
                dv_go = !r_dv_busy && !dv_done;
                dv_a  = mag(r_bd);
                dv_b  = r_g;
            end
            ST_DIVFB: begin
                dv_go = !r_dv_busy && !dv_done;
                dv_a  = mag(r_ad);
                dv_b  = r_g;
            end
            ST_DIVRN: begin
                dv_go = !r_dv_busy && !dv_done;
                dv_a  = mag(r_n);
                dv_b  = r_g;
            end
            ST_DIVRD: begin
                dv_go = !r_dv_busy && !dv_done;
                dv_a  = mag(r_d);
                dv_b  = r_g;
            end
            default: dv_go = 1'b0;
        endcase
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_err   <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: if (start) begin
                    r_func <= i_func;
                    r_an <= i_a_num[W-1:0];
                    r_ad <= i_a_den[W-1:0];
                    r_bn <= i_b_num[W-1:0];
                    r_bd <= i_b_den[W-1:0];
                    r_x  <= mag(i_a_den[W-1:0]);
                    r_y  <= mag(i_b_den[W-1:0]);
                    r_err <= !i_func[1] && (i_a_den[W-1:0] == '0 || i_b_den[W-1:0] == '0);
                    r_n  <= '0;
                    r_d  <= '0;
                end
                ST_GCD1, ST_GCD2: begin
                    if (r_y == '0) r_g <= r_x;
                    else if (dv_done) begin
                        r_x <= r_y;
                        r_y <= (!dv_trial[W]) ? dv_trial[W-1:0]
                                              : {r_dv_r[W-2:0], r_dv_q[W-1]};
                    end
                end
                ST_DIVFA: if (dv_done) r_fa <= {r_dv_q[W-2:0], ~dv_trial[W]};
                ST_DIVFB: if (dv_done) r_fb <= {r_dv_q[W-2:0], ~dv_trial[W]};
                ST_MULTA: r_ta <= sx(W'(r_an * r_fa), r_ad[W-1]);
                ST_MULTB: r_tb <= sx(W'(r_bn * r_fb), r_bd[W-1]);
                ST_MULD:  r_d  <= W'(r_fa * mag(r_ad));
                ST_SUM:   r_n  <= (r_func == FUNC_ADD) ? r_ta + r_tb : r_ta - r_tb;
                ST_MULPN: r_n  <= (r_func == FUNC_MUL) ? W'(r_an * r_bn) : W'(r_an * r_bd);
                ST_MULPD: r_d  <= (r_func == FUNC_MUL) ? W'(r_ad * r_bd) : W'(r_ad * r_bn);
                ST_CHECK: begin
                    r_x <= mag(r_n);
                    r_y <= mag(r_d);
                end
                ST_DIVRN: if (dv_done)
                    r_ta <= sx({r_dv_q[W-2:0], ~dv_trial[W]}, r_n[W-1]);
                ST_DIVRD: if (dv_done) begin
                    r_n <= r_ta;
                    r_d <= sx({r_dv_q[W-2:0], ~dv_trial[W]}, r_d[W-1]);
                end
                default: ;
            endcase
        end
    end

    // Outputs.
    always_comb begin
        busy      = (r_state != ST_IDLE);
        o_valid   = (r_state == ST_DONE);
        o_res_num = IO_BITS'($signed(r_n));
        o_res_den = IO_BITS'($signed(r_d));
        o_err     = r_err;
    end

    a_valid_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("strobe longer than one cycle");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_err) |-> (o_res_num == '0 && o_res_den == '0))
        else $error("error result not zero");
    a_dv_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_dv_busy) else $error("divider busy in idle");
    a_busy_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("strobe without busy");
endmodule

FILE: bench/rational_arith_unit_tb.sv
`timescale 1ns / 1ps
module rational_arith_unit_tb;
    import rau_pkg::*;

    typedef struct {
        t_func       func;
        logic [31:0] a_num;
        logic [31:0] a_den;
        logic [31:0] b_num;
        logic [31:0] b_den;
    } t_operands;

    typedef struct {
        logic [31:0] num;
        logic [31:0] den;
        logic        err;
    } t_fraction;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_func;
    logic signed [31:0] i_a_num, i_a_den, i_b_num, i_b_den;
    logic        o_valid;
    logic signed [31:0] o_res_num, o_res_den;
    logic        o_err;

    t_operands pending_ops[$];
    t_fraction expected_fracs[$];
    int        error_count = 0;
    int        idle_pct = 0;

    rational_arith_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_func(i_func), .i_a_num(i_a_num), .i_a_den(i_a_den),
        .i_b_num(i_b_num), .i_b_den(i_b_den), .o_valid(o_valid),
        .o_res_num(o_res_num), .o_res_den(o_res_den), .o_err(o_err)
    );

    // Clock generation.
    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [31:0] magnitude(logic [31:0] v);
        return v[31] ? -v : v;
    endfunction

    function automatic logic [31:0] gcd32(logic [31:0] x, logic [31:0] y);
        logic [31:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Computes the reduced fraction for one operand beat.
    function automatic t_fraction combine_fractions(t_operands op);
        t_fraction   r;
        logic [31:0] ma, mb, g, fa, fb, ta, tb, n, d, mn, md;
        r.err = 0;
        if (op.func == FUNC_ADD || op.func == FUNC_SUB) begin
            ma = magnitude(op.a_den);
            mb = magnitude(op.b_den);
            if (ma == 0 || mb == 0) begin
                r.num = 0;
                r.den = 0;
                r.err = 1;
                return r;
            end
            g = gcd32(ma, mb);
            fa = mb / g;
            fb = ma / g;
            ta = op.a_num * fa;
            if (op.a_den[31]) ta = -ta;
            tb = op.b_num * fb;
            if (op.b_den[31]) tb = -tb;
            n = (op.func == FUNC_ADD) ? ta + tb : ta - tb;
            d = fa * ma;
        end else if (op.func == FUNC_MUL) begin
            n = op.a_num * op.b_num;
            d = op.a_den * op.b_den;
        end else begin
            n = op.a_num * op.b_den;
            d = op.a_den * op.b_num;
        end
        // Reduce by the common factor, each part keeping its sign.
        if (n != 0 && d != 0) begin
            mn = magnitude(n);
            md = magnitude(d);
            g = gcd32(mn, md);
            n = n[31] ? -(mn / g) : mn / g;
            d = d[31] ? -(md / g) : md / g;
        end
        r.num = n;
        r.den = d;
        return r;
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 20) - 10;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0001;
            2: return $urandom_range(1, 2000) * ($urandom_range(0, 1) ? 6 : -6);
            3: return 32'h8000_0000;
            default: return $urandom();
        endcase
    endfunction

    task automatic add_op(t_func f, logic [31:0] an, logic [31:0] ad,
                          logic [31:0] bn, logic [31:0] bd);
        t_operands op;
        op.func = f;
        op.a_num = an;
        op.a_den = ad;
        op.b_num = bn;
        op.b_den = bd;
        pending_ops.push_back(op);
    endtask

    // Driver: presents one beat at a time and holds start until accepted.
    always @(posedge i_clk) begin
        t_operands op;
        if (!i_rst_n) begin
            start <= 0;
        end else if (start && !busy) begin
            if (pending_ops.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                op = pending_ops.pop_front();
                expected_fracs.push_back(combine_fractions(op));
                i_func <= op.func;
                i_a_num <= op.a_num;
                i_a_den <= op.a_den;
                i_b_num <= op.b_num;
                i_b_den <= op.b_den;
            end else begin
                start <= 0;
            end
        end else if (!start && pending_ops.size() > 0
                     && $urandom_range(0, 99) >= idle_pct) begin
            op = pending_ops.pop_front();
            expected_fracs.push_back(combine_fractions(op));
            i_func <= op.func;
            i_a_num <= op.a_num;
            i_a_den <= op.a_den;
            i_b_num <= op.b_num;
            i_b_den <= op.b_den;
            start <= 1;
        end else if (start && busy) begin
            // Beat not yet taken: hold it steady.
        end
    end

    // Monitor: checks each result strobe against the oldest expectation.
    always @(posedge i_clk) begin
        t_fraction e;
        if (i_rst_n && o_valid) begin
            if (expected_fracs.size() == 0) begin
                $error("unexpected result num=%h den=%h err=%b",
                       o_res_num, o_res_den, o_err);
                error_count++;
            end else begin
                e = expected_fracs.pop_front();
                if (o_res_num !== e.num) begin
                    $error("res_num expected %h actual %h", e.num, o_res_num);
                    error_count++;
                end
                if (o_res_den !== e.den) begin
                    $error("res_den expected %h actual %h", e.den, o_res_den);
                    error_count++;
                end
                if (o_err !== e.err) begin
                    $error("err expected %b actual %b", e.err, o_err);
                    error_count++;
                end
            end
        end
    end

    // Stimulus, idling phases and end of run.
    initial begin
        int phase, wait_cycles;
        i_rst_n = 0;
        start = 0;
        i_func = 0;
        i_a_num = 0;
        i_a_den = 0;
        i_b_num = 0;
        i_b_den = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed beats: every operation, zero denominators, extremes.
        add_op(FUNC_ADD, 1, 2, 1, 3);
        add_op(FUNC_SUB, 1, 2, 1, 2);
        add_op(FUNC_MUL, 2, 3, 3, 4);
        add_op(FUNC_DIV, 2, 3, 4, 9);
        add_op(FUNC_ADD, 1, 0, 1, 3);
        add_op(FUNC_SUB, 1, 3, 1, 0);
        add_op(FUNC_MUL, 0, 5, 3, 0);
        add_op(FUNC_DIV, 3, 5, 0, 7);
        add_op(FUNC_ADD, 0, 4, 0, 6);
        add_op(FUNC_ADD, 1, -4, 1, -6);
        add_op(FUNC_SUB, -5, 6, 7, -10);
        add_op(FUNC_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0001, 3);
        add_op(FUNC_MUL, 32'h8000_0000, 32'h8000_0000, 1, 1);
        add_op(FUNC_MUL, 32'h7FFF_FFFF, 32'h8000_0001, 32'h7FFF_FFFF, 2);
        add_op(FUNC_DIV, 32'h8000_0000, 6, 4, 32'h8000_0000);
        add_op(FUNC_SUB, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000);
        add_op(FUNC_ADD, 65536, 65536, 3, 65537);
        add_op(FUNC_DIV, -6, 4, -9, -2);
        add_op(FUNC_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_op(FUNC_ADD, 0, 0, 0, 0);

        // Random beats in four idling phases.
        for (phase = 0; phase < 4; phase++) begin
            idle_pct = (phase == 1) ? 60 : (phase == 3) ? 26 : 0;
            repeat (200)
                add_op(t_func'($urandom_range(0, 3)), rand_operand(), rand_operand(),
                       rand_operand(), rand_operand());
            while (pending_ops.size() > 0) @(posedge i_clk);
        end

        // Drain outstanding results, bounded well above the longest beat.
        wait_cycles = 0;
        while ((expected_fracs.size() > 0 || start) && wait_cycles < 20000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (300) @(posedge i_clk);
        if (error_count == 0 && expected_fracs.size() == 0)
            $display("rational_arith_unit_tb: done, clean");
        else
            $display("rational_arith_unit_tb: done, errors");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(12 * 16000000);
        $display("rational_arith_unit_tb: done, errors");
        $finish;
    end
endmodule

FILE: filelist.f
design/rau_pkg.sv
design/rational_arith_unit.sv
bench/rational_arith_unit_tb.sv
